[rtl/lse_pkg.sv]
// Shared types, constants and the exp(-x) factor table for the logistic score engine.
package lse_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int ACC_W       = 48;
  localparam int EXP_ENTRIES = FRAC_BITS + 4;
  localparam int EXP_IDX_W   = $clog2(EXP_ENTRIES);
  localparam int QUO_W       = 18;
  localparam int NUM_W       = 49;
  localparam int DEN_W       = 34;

  localparam logic [63:0]      ONE_Q62   = 64'd1 << 62;
  localparam logic [ACC_W-1:0] CLAMP_LIM = ACC_W'(8) << FRAC_BITS;

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_PREDICT = 1'b1;

  typedef logic [EXP_ENTRIES-1:0][63:0] exp_tab_t;

  typedef struct packed {
    logic mem_wr;
    logic item_load;
    logic rd_bias;
    logic rd_coef;
    logic acc_init;
    logic mul_load;
    logic acc_add;
    logic exp_init;
    logic exp_step;
    logic div_init;
    logic div_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic vec_open;
    logic item_last;
    logic exp_done;
    logic div_done;
    logic out_busy;
  } dp_status_t;

  // exp(-2^(j-FRAC_BITS)) in Q2.62: series below one, squaring above
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t     tab;
    logic [63:0]  sum;
    logic [63:0]  term;
    logic [127:0] sq;
    int           s;
    tab = '0;
    for (int j = 0; j < EXP_ENTRIES; j++) begin
      if (j < FRAC_BITS) begin
        s    = FRAC_BITS - j;
        sum  = ONE_Q62;
        term = ONE_Q62;
        for (int n = 1; n < 64; n++) begin
          term = (term >> s) / 64'(n);
          if ((n & 1) != 0) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
        tab[j] = sum;
      end else begin
        sq     = {64'd0, tab[j-1]} * {64'd0, tab[j-1]};
        tab[j] = sq[125:62];
      end
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

[rtl/logistic_score_engine_top.sv]
// Top level of the logistic score engine: sequencer plus datapath.
//
//   channel  | handshake          | fields
//   ---------+--------------------+----------------------------------------------
//   in       | in_valid/in_stall  | cmd, model_sel, term_index, term_value, last_term
//   out      | out_valid/out_stall| probability, linear_score, overflowed
//
// A predictor that opens a vector adds an intercept read step before its coefficient read,
// as the coefficient memory has a single read port. A last predictor then runs the
// exp(-x) unit (four 32x32 partial products per set bit of the clamped |score|), then the
// radix-2 divider, and then loads the output.
// rst clears the accumulator, the vector and saturation flags and out_valid; memory is
// not cleared. A held result does not block input; only the next result waits on it.
module logistic_score_engine_top #(
  parameter int PREDICTOR_COUNT = 16,
  parameter int MODEL_COUNT     = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic [1:0]         model_sel,
  input  logic [4:0]         term_index,
  input  logic signed [31:0] term_value,
  input  logic               last_term,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        probability,
  output logic signed [47:0] linear_score,
  output logic               overflowed
);
  import lse_pkg::*;

  ctrl_cmd_t  ctl;
  dp_status_t status;

  lse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .in_stall (in_stall),
    .status   (status),
    .ctl      (ctl)
  );

  lse_datapath #(
    .PREDICTOR_COUNT (PREDICTOR_COUNT),
    .MODEL_COUNT     (MODEL_COUNT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .status       (status),
    .model_sel    (model_sel),
    .term_index   (term_index),
    .term_value   (term_value),
    .last_term    (last_term),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .probability  (probability),
    .linear_score (linear_score),
    .overflowed   (overflowed)
  );

endmodule

[rtl/lse_ctrl.sv]
// Sequencer for the logistic score engine: handshake, fetch, accumulate, sigmoid, deliver.
module lse_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               cmd,
  output logic               in_stall,
  input  lse_pkg::dp_status_t status,
  output lse_pkg::ctrl_cmd_t  ctl
);
  import lse_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_BIAS    = 10'b0000000010,
    S_COEF    = 10'b0000000100,
    S_MUL     = 10'b0000001000,
    S_ADD     = 10'b0000010000,
    S_CLAMP   = 10'b0000100000,
    S_EXP     = 10'b0001000000,
    S_DIVINIT = 10'b0010000000,
    S_DIV     = 10'b0100000000,
    S_DONE    = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (cmd == CMD_WRITE) begin
            ctl.mem_wr = 1'b1;
          end else begin
            ctl.item_load = 1'b1;
            state_next    = status.vec_open ? S_COEF : S_BIAS;
          end
        end
      end
      S_BIAS: begin
        ctl.rd_bias = 1'b1;
        state_next  = S_COEF;
      end
      S_COEF: begin
        ctl.rd_coef  = 1'b1;
        ctl.acc_init = !status.vec_open;
        state_next   = S_MUL;
      end
      S_MUL: begin
        ctl.mul_load = 1'b1;
        state_next   = S_ADD;
      end
      S_ADD: begin
        ctl.acc_add = 1'b1;
        state_next  = status.item_last ? S_CLAMP : S_IDLE;
      end
      S_CLAMP: begin
        ctl.exp_init = 1'b1;
        state_next   = S_EXP;
      end
      S_EXP: begin
        ctl.exp_step = 1'b1;
        if (status.exp_done) begin
          state_next = S_DIVINIT;
        end
      end
      S_DIVINIT: begin
        ctl.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (status.div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!status.out_busy) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_write_stays_idle: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd == CMD_WRITE) |=> state == S_IDLE)
    else $error("coefficient write started a sequence");

  a_first_fetches_bias: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd == CMD_PREDICT) && !status.vec_open |=> state == S_BIAS)
    else $error("first predictor skipped the intercept fetch");

  a_deliver_from_done: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |=> $past(state == S_DONE) && state == S_IDLE)
    else $error("result delivered outside the done step");

endmodule

[rtl/lse_datapath.sv]
// Datapath: coefficient memory, multiply-accumulate, exp(-x) product unit and divider.
module lse_datapath #(
  parameter int PREDICTOR_COUNT = 16,
  parameter int MODEL_COUNT     = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  lse_pkg::ctrl_cmd_t  ctl,
  output lse_pkg::dp_status_t status,
  input  logic [1:0]          model_sel,
  input  logic [4:0]          term_index,
  input  logic signed [31:0]  term_value,
  input  logic                last_term,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         probability,
  output logic signed [47:0]  linear_score,
  output logic                overflowed
);
  import lse_pkg::*;

  localparam int SLOTS  = PREDICTOR_COUNT + 1;
  localparam int DEPTH  = MODEL_COUNT * SLOTS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [1:0] m, input logic [4:0] s);
    return ADDR_W'(m) * ADDR_W'(SLOTS) + ADDR_W'(s);
  endfunction

  logic [31:0]        weights [DEPTH];
  logic signed [31:0] rdata;

  logic [1:0]         item_model;
  logic [4:0]         item_slot;
  logic signed [31:0] item_value;
  logic               item_last;

  logic signed [ACC_W-1:0] acc;
  logic                    vec_open;
  logic                    sat;
  logic signed [63:0]      prod;

  logic [EXP_ENTRIES-1:0] x;
  logic                   neg;
  logic [63:0]            e;
  logic [EXP_IDX_W-1:0]   j;
  logic [2:0]             k;
  logic [63:0]            pp;
  logic [127:0]           pacc;

  logic [NUM_W-1:0]       rem;
  logic [NUM_W+1:0]       dreg;
  logic [4:0]             dcnt;
  logic [QUO_W-1:0]       quo;

  logic                    wr_ok;
  logic                    model_ok;
  logic                    slot_ok;
  logic [ADDR_W-1:0]       raddr;
  logic signed [31:0]      coef_s;
  logic signed [ACC_W-1:0] term_q;
  logic signed [ACC_W:0]   sum_w;
  logic signed [ACC_W-1:0] sum_sat;
  logic                    sum_ovf;
  logic signed [ACC_W-1:0] acc_neg;
  logic [EXP_ENTRIES-1:0]  x_next;
  logic [63:0]             tab_j;
  logic [31:0]             op_a;
  logic [31:0]             op_b;
  logic [127:0]            pp_shift;
  logic [127:0]            pacc_sum;
  logic [32:0]             e32;
  logic [DEN_W-1:0]        den;
  logic [NUM_W-1:0]        num;
  logic                    ge;
  logic [15:0]             prob_cap;

  assign wr_ok    = (int'(model_sel) < MODEL_COUNT) && (int'(term_index) <= PREDICTOR_COUNT);
  assign model_ok = int'(item_model) < MODEL_COUNT;
  assign slot_ok  = (item_slot != 5'd0) && (int'(item_slot) <= PREDICTOR_COUNT);

  always_comb begin
    raddr = '0;
    if (ctl.rd_bias && model_ok) begin
      raddr = slot_addr(item_model, 5'd0);
    end else if (ctl.rd_coef && model_ok && slot_ok) begin
      raddr = slot_addr(item_model, item_slot);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mem_wr && wr_ok) begin
      weights[slot_addr(model_sel, term_index)] <= term_value;
    end
    if (ctl.rd_bias || ctl.rd_coef) begin
      rdata <= weights[raddr];
    end
  end

  // multiply-accumulate
  assign coef_s  = model_ok ? rdata : 32'sd0;
  assign term_q  = prod[FRAC_BITS+ACC_W-1:FRAC_BITS];
  assign sum_w   = {acc[ACC_W-1], acc} + {term_q[ACC_W-1], term_q};
  assign sum_ovf = sum_w[ACC_W] != sum_w[ACC_W-1];

  always_comb begin
    sum_sat = sum_w[ACC_W-1:0];
    if (sum_ovf) begin
      sum_sat = sum_w[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  // clamp |score| to the sigmoid's range
  assign acc_neg = -acc;
  always_comb begin
    if (!acc[ACC_W-1]) begin
      x_next = (acc >= $signed(CLAMP_LIM)) ? EXP_ENTRIES'(CLAMP_LIM) : acc[EXP_ENTRIES-1:0];
    end else begin
      x_next = (acc <= -$signed(CLAMP_LIM)) ? EXP_ENTRIES'(CLAMP_LIM)
                                            : acc_neg[EXP_ENTRIES-1:0];
    end
  end

  // exp(-x) product: four 32x32 partial products per set bit of x
  assign tab_j = EXP_TAB[j];
  assign op_a  = ((k == 3'd0) || (k == 3'd2)) ? e[31:0] : e[63:32];
  assign op_b  = (k < 3'd2) ? tab_j[31:0] : tab_j[63:32];

  always_comb begin
    case (k)
      3'd1:    pp_shift = {64'd0, pp};
      3'd2:    pp_shift = {32'd0, pp, 32'd0};
      3'd3:    pp_shift = {32'd0, pp, 32'd0};
      3'd4:    pp_shift = {pp, 64'd0};
      default: pp_shift = '0;
    endcase
  end
  assign pacc_sum = pacc + pp_shift;

  // divider operands
  assign e32 = e[62:30];
  assign den = {1'b1, 32'd0} + DEN_W'(e32);
  assign num = neg ? (NUM_W'(e32) << 16) + NUM_W'(den >> 1)
                   : (NUM_W'(1) << 48) + NUM_W'(den >> 1);
  assign ge  = {2'b00, rem} >= dreg;

  assign prob_cap = (quo[QUO_W-1:16] != '0) ? 16'hffff : quo[15:0];

  assign status.vec_open  = vec_open;
  assign status.item_last = item_last;
  assign status.exp_done  = (j == EXP_IDX_W'(EXP_ENTRIES - 1)) && (!x[j] || (k == 3'd4));
  assign status.div_done  = dcnt == 5'd0;
  assign status.out_busy  = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (ctl.item_load) begin
      item_model <= model_sel;
      item_slot  <= term_index;
      item_value <= term_value;
      item_last  <= last_term;
    end
    if (ctl.mul_load) begin
      prod <= coef_s * item_value;
    end
    if (ctl.exp_init) begin
      x   <= x_next;
      neg <= acc[ACC_W-1];
      e   <= ONE_Q62;
      j   <= '0;
      k   <= '0;
    end else if (ctl.exp_step) begin
      if (!x[j]) begin
        j <= j + 1'b1;
      end else begin
        case (k)
          3'd0: begin
            pacc <= '0;
            pp   <= op_a * op_b;
            k    <= 3'd1;
          end
          3'd4: begin
            e <= pacc_sum[125:62];
            k <= 3'd0;
            j <= j + 1'b1;
          end
          default: begin
            pacc <= pacc_sum;
            pp   <= op_a * op_b;
            k    <= k + 3'd1;
          end
        endcase
      end
    end
    if (ctl.div_init) begin
      rem  <= num;
      dreg <= (NUM_W+2)'(den) << (QUO_W - 1);
      dcnt <= 5'(QUO_W - 1);
      quo  <= '0;
    end else if (ctl.div_step) begin
      if (ge) begin
        rem <= rem - dreg[NUM_W-1:0];
      end
      quo  <= {quo[QUO_W-2:0], ge};
      dreg <= dreg >> 1;
      dcnt <= dcnt - 5'd1;
    end
    if (ctl.out_load) begin
      probability  <= prob_cap;
      linear_score <= acc;
      overflowed   <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      vec_open  <= 1'b0;
      sat       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.acc_init) begin
        acc      <= model_ok ? {{(ACC_W-32){rdata[31]}}, rdata} : '0;
        sat      <= 1'b0;
        vec_open <= 1'b1;
      end else if (ctl.acc_add && slot_ok) begin
        acc <= sum_sat;
        if (sum_ovf) begin
          sat <= 1'b1;
        end
      end else if (ctl.out_load) begin
        acc      <= '0;
        sat      <= 1'b0;
        vec_open <= 1'b0;
      end
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> !(out_valid && out_stall))
    else $error("held result overwritten");

  a_add_in_vector: assert property (@(posedge clk) disable iff (rst)
    ctl.acc_add |-> vec_open)
    else $error("accumulate outside an open vector");

  a_exp_bounded: assert property (@(posedge clk) disable iff (rst)
    ctl.exp_step && status.exp_done |=> e <= ONE_Q62)
    else $error("exp product above one");

endmodule

[test/testbench.sv]
// Self-checking testbench for the logistic score engine, with its own scoring predictor.
`timescale 1ns / 100ps

module testbench;

  import lse_pkg::*;

  localparam int MODELS     = 3;
  localparam int PREDICTORS = 16;
  localparam int EXP_BITS   = FRAC_BITS + 4;

  localparam logic [63:0]        Q62_ONE = 64'd1 << 62;
  localparam logic [63:0]        CLAMP   = 64'd8 << FRAC_BITS;
  localparam logic signed [63:0] ACC_MAX = 64'sh0000_7fff_ffff_ffff;
  localparam logic signed [63:0] ACC_MIN = 64'shffff_8000_0000_0000;

  typedef struct {
    logic               op;
    logic [1:0]         model;
    logic [4:0]         slot;
    logic signed [31:0] value;
    logic               ends_vector;
  } term_t;

  typedef struct {
    logic [15:0]        prob;
    logic signed [47:0] score;
    logic               ovf;
  } score_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               cmd = 1'b0;
  logic [1:0]         model_sel = '0;
  logic [4:0]         term_index = '0;
  logic signed [31:0] term_value = '0;
  logic               last_term = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [15:0]        probability;
  logic signed [47:0] linear_score;
  logic               overflowed;

  term_t       pending_terms[$];
  score_t      score_due[$];
  term_t       drive_beat;
  logic        in_taken = 1'b0;
  int          stim_total = 0;
  int          beats_in = 0;
  int          bad_beats = 0;

  logic [31:0]        weights [MODELS][PREDICTORS+1];
  logic signed [63:0] run_score = '0;
  logic               vec_open = 1'b0;
  logic               sat_seen = 1'b0;
  logic [63:0]        exp_factor [EXP_BITS];

  logistic_score_engine_top uut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  function automatic logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // exp(-2^(j-FRAC_BITS)) in Q2.62
  initial begin : build_exp_factors
    int          s;
    logic [63:0] sum;
    logic [63:0] term;
    for (int j = 0; j < EXP_BITS; j++) begin
      if (j < FRAC_BITS) begin
        s    = FRAC_BITS - j;
        sum  = Q62_ONE;
        term = Q62_ONE;
        for (int n = 1; n < 64 && term != 0; n++) begin
          term = (term >> s) / 64'(n);
          if (n % 2 == 1) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
        exp_factor[j] = sum;
      end else begin
        exp_factor[j] = q62_mul(exp_factor[j-1], exp_factor[j-1]);
      end
    end
  end

  function automatic logic [15:0] logistic_q16(logic signed [63:0] score);
    logic [63:0] mag;
    logic [63:0] e;
    logic [63:0] e32;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] p;
    mag = (score < 0) ? -score : score;
    if (mag > CLAMP) mag = CLAMP;
    e = Q62_ONE;
    for (int j = 0; j < EXP_BITS; j++) begin
      if (mag[j]) e = q62_mul(e, exp_factor[j]);
    end
    e32 = e >> 30;
    den = (64'd1 << 32) + e32;
    num = (score >= 0) ? (64'd1 << 48) : (e32 << 16);
    p   = (num + den / 2) / den;
    return (p > 64'd65535) ? 16'hffff : p[15:0];
  endfunction

  function automatic logic signed [31:0] coef_at(logic [1:0] m, logic [4:0] s);
    if (m >= MODELS || s > PREDICTORS) return '0;
    return weights[m][s];
  endfunction

  task automatic absorb_term(term_t t);
    logic signed [63:0] w;
    logic signed [63:0] v;
    logic signed [63:0] sum;
    score_t             r;
    if (t.op == CMD_WRITE) begin
      if (t.model < MODELS && t.slot <= PREDICTORS) weights[t.model][t.slot] = t.value;
    end else begin
      if (!vec_open) begin
        run_score = coef_at(t.model, 5'd0);
        sat_seen  = 1'b0;
        vec_open  = 1'b1;
      end
      if (t.slot >= 1 && t.slot <= PREDICTORS) begin
        w   = coef_at(t.model, t.slot);
        v   = t.value;
        sum = run_score + ((w * v) >>> FRAC_BITS);
        if (sum > ACC_MAX) begin
          sum      = ACC_MAX;
          sat_seen = 1'b1;
        end else if (sum < ACC_MIN) begin
          sum      = ACC_MIN;
          sat_seen = 1'b1;
        end
        run_score = sum;
      end
      if (t.ends_vector) begin
        r.prob  = logistic_q16(run_score);
        r.score = run_score[47:0];
        r.ovf   = sat_seen;
        score_due.push_back(r);
        vec_open  = 1'b0;
        sat_seen  = 1'b0;
        run_score = '0;
      end
    end
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return $urandom;
      1: begin
        case ($urandom_range(4))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hffff_ffff;
          default: return 32'h0001_0000;
        endcase
      end
      2, 3: return int'($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
      default: return int'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    endcase
  endfunction

  task automatic push_term(logic op, logic [1:0] m, logic [4:0] s, logic [31:0] v,
                           logic ends);
    term_t t;
    t = '{op, m, s, v, ends};
    pending_terms.push_back(t);
    stim_total++;
  endtask

  task automatic push_random_write(inout int useful);
    logic [1:0] m;
    logic [4:0] s;
    m = 2'($urandom_range(3));
    s = ($urandom_range(7) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(PREDICTORS));
    push_term(CMD_WRITE, m, s, pick_value(), 1'($urandom_range(1)));
    if (m < MODELS && s <= PREDICTORS) useful++;
  endtask

  function automatic int idle_pct(bit rx);
    int phase;
    phase = (stim_total == 0) ? 0 : beats_in * 3 / stim_total;
    case (phase)
      0: return rx ? 78 : 26;
      1: return rx ? 26 : 78;
      default: return 0;
    endcase
  endfunction

  initial begin
    int         useful;
    int         len;
    int         pick;
    logic [1:0] m;
    logic [1:0] tm;
    logic [4:0] s;
    useful = 0;
    for (int mi = 0; mi < MODELS; mi++) begin
      for (int si = 0; si <= PREDICTORS; si++) begin
        push_term(CMD_WRITE, 2'(mi), 5'(si), pick_value(), 1'b0);
      end
    end

    push_term(CMD_WRITE, 2'd0, 5'd0, 32'h0008_0000, 1'b0);
    push_term(CMD_PREDICT, 2'd0, 5'd0, 32'h0000_0000, 1'b1);
    push_term(CMD_WRITE, 2'd1, 5'd0, 32'hfff7_ffff, 1'b0);
    push_term(CMD_PREDICT, 2'd1, 5'd16, 32'h0000_0000, 1'b1);
    push_term(CMD_WRITE, 2'd3, 5'd5, 32'h7fff_ffff, 1'b1);
    push_term(CMD_WRITE, 2'd0, 5'd17, 32'h8000_0000, 1'b0);
    push_term(CMD_WRITE, 2'd2, 5'd31, 32'h7fff_ffff, 1'b0);
    push_term(CMD_PREDICT, 2'd3, 5'd1, 32'h7fff_ffff, 1'b1);
    push_term(CMD_WRITE, 2'd0, 5'd1, 32'h7fff_ffff, 1'b0);
    push_term(CMD_WRITE, 2'd0, 5'd2, 32'h7fff_ffff, 1'b0);
    push_term(CMD_WRITE, 2'd0, 5'd3, 32'h8000_0000, 1'b0);
    push_term(CMD_PREDICT, 2'd0, 5'd1, 32'h7fff_ffff, 1'b0);
    push_term(CMD_PREDICT, 2'd0, 5'd2, 32'h7fff_ffff, 1'b0);
    push_term(CMD_PREDICT, 2'd0, 5'd3, 32'h8000_0000, 1'b0);
    push_term(CMD_PREDICT, 2'd0, 5'd1, 32'h7fff_ffff, 1'b1);
    push_term(CMD_PREDICT, 2'd0, 5'd1, 32'h8000_0000, 1'b0);
    push_term(CMD_PREDICT, 2'd0, 5'd2, 32'h8000_0000, 1'b0);
    push_term(CMD_PREDICT, 2'd0, 5'd1, 32'h8000_0000, 1'b1);
    push_term(CMD_PREDICT, 2'd2, 5'd4, 32'h0001_0000, 1'b0);
    push_term(CMD_WRITE, 2'd2, 5'd4, 32'h0002_0000, 1'b0);
    push_term(CMD_PREDICT, 2'd2, 5'd4, 32'h0001_0000, 1'b0);
    push_term(CMD_PREDICT, 2'd1, 5'd5, 32'hffff_0000, 1'b0);
    push_term(CMD_PREDICT, 2'd0, 5'd31, 32'h0000_0001, 1'b1);
    push_term(CMD_WRITE, 2'd1, 5'd6, 32'hffff_ffff, 1'b0);
    push_term(CMD_PREDICT, 2'd1, 5'd6, 32'h0000_0001, 1'b1);

    while (useful < 1250) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        push_random_write(useful);
      end else if (pick < 12) begin
        push_term(CMD_PREDICT, 2'($urandom_range(3)), 5'($urandom_range(31)), pick_value(),
                  1'($urandom_range(1)));
        useful++;
      end else begin
        len = $urandom_range(1, 6);
        m   = 2'($urandom_range(MODELS - 1));
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(19) == 0) push_random_write(useful);
          tm = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : m;
          if ($urandom_range(14) == 0) begin
            s = $urandom_range(1) ? 5'd0 : 5'($urandom_range(31, PREDICTORS + 1));
          end else begin
            s = 5'($urandom_range(1, PREDICTORS));
          end
          push_term(CMD_PREDICT, tm, s, pick_value(), k == len - 1);
          useful++;
        end
      end
    end

    wait (beats_in == stim_total);
    wait (score_due.size() == 0);
    repeat (300) @(posedge clk);
    if (bad_beats == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(negedge clk) begin
    if (!rst) begin
      out_stall <= ($urandom_range(99) < idle_pct(1'b1));
      if (!in_valid || in_taken) begin
        if (pending_terms.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          drive_beat = pending_terms.pop_front();
          in_valid   <= 1'b1;
          cmd        <= drive_beat.op;
          model_sel  <= drive_beat.model;
          term_index <= drive_beat.slot;
          term_value <= drive_beat.value;
          last_term  <= drive_beat.ends_vector;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    score_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (score_due.size() == 0) begin
          if (bad_beats < 10) begin
            $display("unexpected result: prob %0d score %0d ovf %0d",
                     probability, linear_score, overflowed);
          end
          bad_beats++;
        end else begin
          want = score_due.pop_front();
          if (probability !== want.prob || linear_score !== want.score ||
              overflowed !== want.ovf) begin
            if (bad_beats < 10) begin
              $display("mismatch: expected prob %0d score %0d ovf %0d, got %0d %0d %0d",
                       want.prob, want.score, want.ovf,
                       probability, linear_score, overflowed);
            end
            bad_beats++;
          end
        end
      end
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        absorb_term('{cmd, model_sel, term_index, term_value, last_term});
        beats_in++;
      end
    end
  end

endmodule
